// ----- rtl/core/sbam_pkg.sv -----
// Package for the sparse block allocation map: sizes, codes and control structs.
package sbam_pkg;

  localparam int unsigned MAX_BLOCKS        = 1024;
  localparam int unsigned SECTORS_PER_BLOCK = 4096;
  localparam int unsigned BLOCK_STRIDE      = 4097;

  localparam int unsigned SECTOR_W   = 32;
  localparam int unsigned OFFSET_W   = 32;
  localparam int unsigned BLK_CNT_W  = 11;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned SIB_W       = $clog2(SECTORS_PER_BLOCK);
  localparam int unsigned BLOCK_W     = SECTOR_W - SIB_W;
  localparam int unsigned BLK_IDX_W   = $clog2(MAX_BLOCKS);
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned BIT_SEL_W   = $clog2(WORD_W);
  localparam int unsigned MAP_WORDS   = MAX_BLOCKS * (SECTORS_PER_BLOCK / WORD_W);
  localparam int unsigned MAP_ADDR_W  = $clog2(MAP_WORDS);

  localparam logic [BLK_CNT_W-1:0] MAX_BLOCKS_C      = BLK_CNT_W'(MAX_BLOCKS);
  localparam logic [BLK_CNT_W-1:0] BLOCK_COUNT_RST   = BLK_CNT_W'(1024);
  localparam logic [OFFSET_W-1:0]  FIRST_FREE_RST    = OFFSET_W'(1536);
  localparam logic [OFFSET_W:0]    BLOCK_STRIDE_C    = (OFFSET_W + 1)'(BLOCK_STRIDE);

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK  = 2'd0,
    STATUS_OOR = 2'd1,
    STATUS_OVF = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_COUNT = 2'd0,
    REG_FIRST_FREE  = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic commit;
  } sbam_cmd_t;

  typedef struct packed {
    logic clr_last;
  } sbam_sts_t;

endpackage

// ----- rtl/core/sbam_if.sv -----
// Channel interfaces: item input, result output and register write.
interface sbam_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [sbam_pkg::SECTOR_W-1:0] sector_index;
  logic                          all_zero;

  modport source (output valid, operation, sector_index, all_zero, input ready);
  modport sink   (input valid, operation, sector_index, all_zero, output ready);
endinterface

interface sbam_out_if;
  logic                          valid;
  logic                          ready;
  logic [sbam_pkg::STATUS_W-1:0] status;
  logic                          present;
  logic                          newly_allocated;
  logic [sbam_pkg::OFFSET_W-1:0] block_offset;
  logic [sbam_pkg::SIB_W-1:0]    sector_in_block;
  logic                          sector_marked;

  modport source (output valid, status, present, newly_allocated, block_offset,
                  sector_in_block, sector_marked, input ready);
  modport sink   (input valid, status, present, newly_allocated, block_offset,
                  sector_in_block, sector_marked, output ready);
endinterface

interface sbam_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sbam_pkg::CFG_IDX_W-1:0]  index;
  logic [sbam_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/sparse_block_allocation_map.sv -----
// Flow: on acceptance the item and the memory reads are registered; in EXEC the
//   result register loads once it is free. One item at a time: each item does a read
//   of the table, valid and bitmap memories, then a write-back, on a single port per memory.
// Reset: registers and free pointer load at once; the block valid bits and all 65536 words
//   of the sector bitmap are then swept to zero, with in_i.ready low. Writes always taken.
module sparse_block_allocation_map (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbam_in_if.sink    in_i,
  sbam_out_if.source out_o,
  sbam_cfg_if.sink   cfg_i
);
  import sbam_pkg::*;

  sbam_cmd_t cmd;
  sbam_sts_t sts;
  logic      cfg_we;

  // register writes must come only while the block is idle (not enforced); port never stalls
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  // Controller: the clear sweep, then IDLE (take a transaction, launch memory
  // reads) and EXEC (resolve allocation, write back, load result register).
  // EXEC waits while the result register still holds an untaken transaction.
  sbam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: sector index splits into block number (top bits) and sector in
  // block (low 12 bits); the bitmap word is addressed by the block and the top
  // six bits of the sector in block.
  sbam_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .operation_i       (in_i.operation),
    .sector_index_i    (in_i.sector_index),
    .all_zero_i        (in_i.all_zero),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .status_o          (out_o.status),
    .present_o         (out_o.present),
    .newly_allocated_o (out_o.newly_allocated),
    .block_offset_o    (out_o.block_offset),
    .sector_in_block_o (out_o.sector_in_block),
    .sector_marked_o   (out_o.sector_marked)
  );

endmodule

// ----- rtl/core/sbam_ctrl.sv -----
// Controller FSM: bitmap clear sweep, item sequencing, result handshake.
module sbam_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  sbam_pkg::sbam_sts_t sts_i,
  output sbam_pkg::sbam_cmd_t cmd_o
);
  import sbam_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC:  if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_en = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EXEC:  cmd_o.commit = slot_free;
      default:  cmd_o = '0;
    endcase
  end

  // result register valid: set on commit, dropped when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/core/sbam_dp.sv -----
// Datapath: block table, valid bits, sector bitmap memory, free pointer, result.
module sbam_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sbam_pkg::sbam_cmd_t               cmd_i,
  output sbam_pkg::sbam_sts_t               sts_o,
  input  logic                              operation_i,
  input  logic [sbam_pkg::SECTOR_W-1:0]     sector_index_i,
  input  logic                              all_zero_i,
  input  logic                              cfg_we_i,
  input  logic [sbam_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sbam_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic [sbam_pkg::STATUS_W-1:0]     status_o,
  output logic                              present_o,
  output logic                              newly_allocated_o,
  output logic [sbam_pkg::OFFSET_W-1:0]     block_offset_o,
  output logic [sbam_pkg::SIB_W-1:0]        sector_in_block_o,
  output logic                              sector_marked_o
);
  import sbam_pkg::*;

  // configuration and free pointer
  logic [BLK_CNT_W-1:0] block_count_q;
  logic [OFFSET_W-1:0]  free_q;

  // item registers
  logic                 wr_q;
  logic [BLOCK_W-1:0]   block_q;
  logic [SIB_W-1:0]     sib_q;

  // memories
  logic [OFFSET_W-1:0]  table_mem [MAX_BLOCKS];
  logic [WORD_W-1:0]    map_mem   [MAP_WORDS];
  logic                 valid_mem [MAX_BLOCKS];
  logic [OFFSET_W-1:0]  table_rd_q;
  logic [WORD_W-1:0]    map_rd_q;
  logic                 valid_rd_q;
  logic [MAP_ADDR_W-1:0] clr_cnt_q;

  // incoming address split
  logic [BLOCK_W-1:0]    in_block;
  logic [SIB_W-1:0]      in_sib;
  logic [MAP_ADDR_W-1:0] in_word_addr;
  logic [MAP_ADDR_W-1:0] word_addr;
  logic [BLK_IDX_W-1:0]  blk_idx;
  logic [BIT_SEL_W-1:0]  bit_sel;

  // execute-cycle decisions
  logic [BLK_CNT_W-1:0]  limit;
  logic                  in_range, blk_valid, overflow, want_alloc;
  logic                  alloc, fail, mark, present;
  logic [OFFSET_W:0]     next_free;
  logic [WORD_W-1:0]     map_wr_word;

  assign in_block     = sector_index_i[SECTOR_W-1:SIB_W];
  assign in_sib       = sector_index_i[SIB_W-1:0];
  assign in_word_addr = {in_block[BLK_IDX_W-1:0], in_sib[SIB_W-1:BIT_SEL_W]};
  assign blk_idx      = block_q[BLK_IDX_W-1:0];
  assign bit_sel      = sib_q[BIT_SEL_W-1:0];
  assign word_addr    = {blk_idx, sib_q[SIB_W-1:BIT_SEL_W]};

  assign limit      = (block_count_q > MAX_BLOCKS_C) ? MAX_BLOCKS_C : block_count_q;
  assign in_range   = block_q < BLOCK_W'(limit);
  assign blk_valid  = valid_rd_q;
  assign next_free  = {1'b0, free_q} + BLOCK_STRIDE_C;
  assign overflow   = next_free[OFFSET_W];
  assign want_alloc = in_range && wr_q && !blk_valid;
  assign alloc      = want_alloc && !overflow;
  assign fail       = want_alloc && overflow;
  assign mark       = in_range && wr_q && !fail;
  assign present    = in_range && (blk_valid || alloc);
  assign map_wr_word = map_rd_q | (WORD_W'(1) << bit_sel);

  assign sts_o.clr_last = clr_cnt_q == '1;

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      wr_q    <= (operation_i == OP_WRITE) && !all_zero_i;
      block_q <= in_block;
      sib_q   <= in_sib;
    end
  end

  // table memory: read on load, write on allocation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      table_rd_q <= table_mem[in_block[BLK_IDX_W-1:0]];
    end
    if (cmd_i.commit && alloc) begin
      table_mem[blk_idx] <= free_q;
    end
  end

  // block valid memory: cleared by the sweep, read on load, set on allocation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      valid_rd_q <= valid_mem[in_block[BLK_IDX_W-1:0]];
    end
    if (cmd_i.clr_en) begin
      valid_mem[clr_cnt_q[BLK_IDX_W-1:0]] <= 1'b0;
    end else if (cmd_i.commit && alloc) begin
      valid_mem[blk_idx] <= 1'b1;
    end
  end

  // bitmap memory: clear sweep or read-modify-write
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      map_rd_q <= map_mem[in_word_addr];
    end
    if (cmd_i.clr_en) begin
      map_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.commit && mark) begin
      map_mem[word_addr] <= map_wr_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + MAP_ADDR_W'(1);
    end
  end

  // registers and free pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= BLOCK_COUNT_RST;
      free_q        <= FIRST_FREE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BLOCK_COUNT: block_count_q <= cfg_data_i[BLK_CNT_W-1:0];
        REG_FIRST_FREE:  free_q        <= cfg_data_i[OFFSET_W-1:0];
        default: ;
      endcase
    end else if (cmd_i.commit && alloc) begin
      free_q <= next_free[OFFSET_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (!in_range) begin
        status_o <= STATUS_OOR;
      end else if (fail) begin
        status_o <= STATUS_OVF;
      end else begin
        status_o <= STATUS_OK;
      end
      present_o         <= present;
      newly_allocated_o <= alloc;
      block_offset_o    <= !present ? '0 : (alloc ? free_q : table_rd_q);
      sector_in_block_o <= sib_q;
      sector_marked_o   <= present && (mark || map_rd_q[bit_sel]);
    end
  end

endmodule

// ----- rtl/core/sbam_checker.sv -----
// Port-level checks for the sparse block allocation map, bound to the top level.
module sbam_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [sbam_pkg::STATUS_W-1:0] status_i,
  input logic                          present_i,
  input logic                          newly_allocated_i,
  input logic [sbam_pkg::OFFSET_W-1:0] block_offset_i,
  input logic                          sector_marked_i
);
  import sbam_pkg::*;

  // one item in flight: no transaction straight after another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken on consecutive cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(block_offset_i)))
    else $error("stalled result dropped or changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i != STATUS_OK) |->
      (!present_i && !newly_allocated_i && !sector_marked_i && block_offset_i == '0))
    else $error("failed item reports a block");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && newly_allocated_i) |->
      (present_i && sector_marked_i && status_i == STATUS_OK))
    else $error("allocation without mark");

endmodule

bind sparse_block_allocation_map sbam_checker u_sbam_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .status_i          (out_o.status),
  .present_i         (out_o.present),
  .newly_allocated_i (out_o.newly_allocated),
  .block_offset_i    (out_o.block_offset),
  .sector_marked_i   (out_o.sector_marked)
);

// ----- tb/tb_sparse_block_allocation_map.sv -----
// Self-checking testbench for the sparse block allocation map: lookups, allocation, overflow.
module tb_sparse_block_allocation_map;
  import sbam_pkg::*;

  // Receiver back-pressure stretch, and the no-progress limit. The limit covers the
  // bitmap sweep after reset several times over.
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned STALL_LIMIT    = 400000;
  localparam int unsigned PRINT_CAP      = 40;
  localparam int unsigned RECENT_DEPTH   = 64;

  typedef struct packed {
    op_e                 op;
    logic [SECTOR_W-1:0] sector;
    logic                zero;
  } request_t;

  typedef struct packed {
    status_e             status;
    logic                present;
    logic                fresh;
    logic [OFFSET_W-1:0] offset;
    logic [SIB_W-1:0]    sib;
    logic                marked;
  } lookup_t;

  logic clk_i;
  logic rst_ni;

  sbam_in_if  in_if ();
  sbam_out_if out_if ();
  sbam_cfg_if cfg_if ();

  sparse_block_allocation_map i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // --------------------------------------------------------------------------
  // Allocation map predictor: own copy of registers, table, valid bits, bitmap
  // --------------------------------------------------------------------------
  logic [BLK_CNT_W-1:0] cfg_block_count = BLOCK_COUNT_RST;
  logic [OFFSET_W-1:0]  cfg_first_free  = FIRST_FREE_RST;
  logic [OFFSET_W-1:0]  free_ptr        = FIRST_FREE_RST;
  bit                   blk_valid [MAX_BLOCKS];
  logic [OFFSET_W-1:0]  blk_base  [MAX_BLOCKS];
  bit                   sector_marks [int unsigned];  // key {block, sector in block}

  int unsigned n_alloc, n_ovf, n_oor, n_marked, n_cfg_writes;

  function automatic lookup_t predict_lookup(op_e op, logic [SECTOR_W-1:0] sector, logic zero);
    lookup_t             r;
    logic [BLOCK_W-1:0]  blk;
    int unsigned         lim;
    int unsigned         key;
    logic [OFFSET_W:0]   next_ptr;
    r        = '0;
    r.status = STATUS_OK;
    blk      = sector[SECTOR_W-1:SIB_W];
    r.sib    = sector[SIB_W-1:0];
    lim      = (cfg_block_count > MAX_BLOCKS_C) ? MAX_BLOCKS : int'(cfg_block_count);
    if (blk >= lim) begin
      r.status = STATUS_OOR;
      n_oor++;
    end else begin
      key = 32'({blk[BLK_IDX_W-1:0], r.sib});
      if (op == OP_WRITE && !zero) begin
        if (!blk_valid[blk[BLK_IDX_W-1:0]]) begin
          next_ptr = {1'b0, free_ptr} + BLOCK_STRIDE_C;
          if (next_ptr[OFFSET_W]) begin
            // free pointer would wrap: nothing allocated, nothing marked
            r.status = STATUS_OVF;
            n_ovf++;
          end else begin
            blk_valid[blk[BLK_IDX_W-1:0]] = 1'b1;
            blk_base[blk[BLK_IDX_W-1:0]]  = free_ptr;
            free_ptr = next_ptr[OFFSET_W-1:0];
            r.fresh  = 1'b1;
            n_alloc++;
          end
        end
        if (r.status == STATUS_OK) sector_marks[key] = 1'b1;
      end
      if (r.status == STATUS_OK && blk_valid[blk[BLK_IDX_W-1:0]]) begin
        r.present = 1'b1;
        r.offset  = blk_base[blk[BLK_IDX_W-1:0]];
        r.marked  = (sector_marks.exists(key) != 0);
        if (r.marked) n_marked++;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Shared state between stimulus, driver and monitor
  // --------------------------------------------------------------------------
  request_t            pending_requests [$];
  lookup_t             expected_lookups [$];
  logic [SECTOR_W-1:0] recent_writes [$];   // sectors revisited to hit marked bits

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned span_blocks;
  int unsigned hold_asked;
  int unsigned hold_taken;
  int unsigned hold_left;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned idle_cycles;

  // clock: 20 time units
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("MISMATCH result %0d: %s got 0x%0h, want 0x%0h", results_seen, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Driver: request channel. Predicts at the accepting edge so the expected
  // order follows the transaction order exactly.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    request_t nxt;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        expected_lookups.push_back(predict_lookup(op_e'(in_if.operation), in_if.sector_index,
                                                  in_if.all_zero));
      // valid stays up until taken; only then is the next request considered
      if (!in_if.valid || in_if.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = pending_requests.pop_front();
          in_if.valid        <= 1'b1;
          in_if.operation    <= nxt.op;
          in_if.sector_index <= nxt.sector;
          in_if.all_zero     <= nxt.zero;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: result channel, field-by-field check against the oldest
  // expectation; also owns the receiver's ready and the long hold-off.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_lookups.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_if.block_offset, '0);
        end else begin
          want = expected_lookups.pop_front();
          if (out_if.status !== want.status)
            report_mismatch("status", 32'(out_if.status), 32'(want.status));
          if (out_if.present !== want.present)
            report_mismatch("present", 32'(out_if.present), 32'(want.present));
          if (out_if.newly_allocated !== want.fresh)
            report_mismatch("newly_allocated", 32'(out_if.newly_allocated), 32'(want.fresh));
          if (out_if.block_offset !== want.offset)
            report_mismatch("block_offset", out_if.block_offset, want.offset);
          if (out_if.sector_in_block !== want.sib)
            report_mismatch("sector_in_block", 32'(out_if.sector_in_block), 32'(want.sib));
          if (out_if.sector_marked !== want.marked)
            report_mismatch("sector_marked", 32'(out_if.sector_marked), 32'(want.marked));
        end
      end
      if (hold_asked != hold_taken) begin
        hold_taken = hold_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: any transaction on any channel counts as progress
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_request(op_e op, logic [SECTOR_W-1:0] sector, logic zero);
    request_t req;
    req.op     = op;
    req.sector = sector;
    req.zero   = zero;
    pending_requests.push_back(req);
    if (op == OP_WRITE && !zero) begin
      recent_writes.push_back(sector);
      if (recent_writes.size() > RECENT_DEPTH) void'(recent_writes.pop_front());
    end
  endtask

  // Mostly a small working set of blocks so that allocations get reused and
  // marked sectors get read back; some full-width noise and near-limit blocks.
  task automatic add_random_requests(int unsigned count);
    int unsigned         blk;
    logic [SIB_W-1:0]    sib;
    logic [SECTOR_W-1:0] sector;
    op_e                 op;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0: sector = $urandom();
        1, 2, 3: begin
          if (recent_writes.size() != 0)
            sector = recent_writes[$urandom_range(recent_writes.size() - 1)];
          else
            sector = $urandom();
        end
        default: begin
          if ($urandom_range(3) == 0 || span_blocks < 24)
            blk = $urandom_range(span_blocks + 1);
          else
            blk = $urandom_range(23);
          case ($urandom_range(3))
            0:       sib = '0;
            1:       sib = '1;
            default: sib = SIB_W'($urandom_range(SECTORS_PER_BLOCK - 1));
          endcase
          sector = {BLOCK_W'(blk), sib};
        end
      endcase
      op = $urandom_range(1) ? OP_WRITE : OP_READ;
      add_request(op, sector, $urandom_range(4) == 0);
    end
  endtask

  // Sender pause: nothing queued, nothing in flight, nothing owed
  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_if.valid || expected_lookups.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    n_cfg_writes++;
    case (idx)
      REG_BLOCK_COUNT: cfg_block_count = value[BLK_CNT_W-1:0];
      REG_FIRST_FREE: begin
        cfg_first_free = value;
        free_ptr       = value;   // pointer reloads at once
      end
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Registers change only with the block idle
  task automatic set_config(logic [BLK_CNT_W-1:0] count, logic [OFFSET_W-1:0] first_free);
    wait_drained();
    write_reg(REG_BLOCK_COUNT, CFG_DATA_W'(count));
    write_reg(REG_FIRST_FREE, first_free);
    span_blocks = (count > MAX_BLOCKS_C) ? MAX_BLOCKS : int'(count);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.operation    = OP_READ;
    in_if.sector_index = '0;
    in_if.all_zero     = 1'b0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_BLOCK_COUNT;
    cfg_if.data        = '0;
    tx_idle_pct        = 37;
    rx_idle_pct        = 88;
    span_blocks        = MAX_BLOCKS;
    hold_asked         = 0;
    hold_taken         = 0;
    hold_left          = 0;
    results_seen       = 0;
    mismatches         = 0;
    idle_cycles        = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset settings: first allocation, zero writes, block edges,
    // out-of-range block numbers, full-width sector index
    add_request(OP_READ,  32'h0000_0000, 1'b0);  // nothing allocated yet
    add_request(OP_WRITE, 32'h0000_0000, 1'b1);  // zero data: lookup only
    add_request(OP_WRITE, 32'h0000_0000, 1'b0);  // allocates at the reset offset
    add_request(OP_READ,  32'h0000_0000, 1'b0);
    add_request(OP_READ,  32'h0000_0001, 1'b0);  // present but unmarked
    add_request(OP_WRITE, 32'h0000_0FFF, 1'b0);  // last sector of block 0
    add_request(OP_WRITE, 32'h0000_1000, 1'b0);  // block 1: next stride
    add_request(OP_WRITE, 32'h0000_1000, 1'b0);  // already allocated
    add_request(OP_READ,  32'h003F_FFFF, 1'b0);  // last in-range sector
    add_request(OP_WRITE, 32'h003F_FFFF, 1'b1);
    add_request(OP_WRITE, 32'h003F_FFFF, 1'b0);
    add_request(OP_READ,  32'h0040_0000, 1'b0);  // first out-of-range block
    add_request(OP_WRITE, 32'h0040_0000, 1'b0);
    add_request(OP_WRITE, 32'hFFFF_FFFF, 1'b0);
    add_request(OP_READ,  32'hFFFF_FFFF, 1'b1);
    add_request(OP_WRITE, 32'h0000_0002, 1'b1);  // zero write into allocated block
    add_request(OP_READ,  32'h0000_0002, 1'b0);
    wait_drained();

    // Free pointer at the top: exactly one more block fits, then overflow
    write_reg(REG_FIRST_FREE, 32'hFFFF_EFFE);
    add_request(OP_WRITE, 32'h0000_5007, 1'b0);
    add_request(OP_WRITE, 32'h0000_6000, 1'b0);  // would wrap
    add_request(OP_READ,  32'h0000_6000, 1'b0);
    add_request(OP_WRITE, 32'h0000_6001, 1'b1);
    add_request(OP_WRITE, 32'h0000_5008, 1'b0);  // existing block unaffected

    set_config(11'd16, 32'h0000_0000);
    add_random_requests(110);

    // swap idling: busy sender gaps, mostly ready receiver
    wait_drained();
    tx_idle_pct = 88;
    rx_idle_pct = 37;
    set_config(11'd2047, 32'hFFFF_FFFF);           // count clamps to the table size
    add_request(OP_READ,  32'h0040_0000, 1'b0);
    add_request(OP_WRITE, 32'h0000_7000, 1'b0);    // pointer already at the limit
    add_random_requests(70);

    set_config(11'd0, 32'h0000_1234);              // every block out of range
    add_random_requests(20);

    set_config(11'd1, 32'hFFFF_0000);
    add_random_requests(40);

    // no idling; receiver holds off while the sender keeps offering
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(11'd1024, $urandom_range(32'h00FF_FFFF));
    add_random_requests(60);
    hold_asked++;
    wait_drained();
    add_random_requests(70);
    wait_drained();
    add_random_requests(70);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (expected_lookups.size() != 0)
      report_mismatch("results never delivered", expected_lookups.size(), 0);

    $display("Run covered %0d results over %0d register writes and six settings:",
             results_seen, n_cfg_writes);
    $display("  %0d allocations, %0d overflows, %0d out of range, %0d marked hits",
             n_alloc, n_ovf, n_oor, n_marked);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/sbam_pkg.sv
rtl/core/sbam_if.sv
rtl/core/sbam_ctrl.sv
rtl/core/sbam_dp.sv
rtl/core/sparse_block_allocation_map.sv
rtl/core/sbam_checker.sv
tb/tb_sparse_block_allocation_map.sv
